// ----- rtl/rpt_pkg.sv -----
// shared constants and types for the retransmit pending table
`timescale 1ns / 1ps
package rpt_pkg;

  localparam int SLOTS    = 8;
  localparam int SlotW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 6;
  localparam int HANDLE_W = 16;
  localparam int CFG_W    = 7;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [CFG_W-1:0] RETX_RESET = CFG_W'(5);
  localparam logic [SlotW-1:0] LAST_SLOT  = SlotW'(SLOTS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_DEREGISTER = 2'd1,
    REQ_TAKE       = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_DUP       = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_NONE      = 3'd4
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   sent_time;
    logic [HANDLE_W-1:0] packet;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;

endpackage

// ----- rtl/retransmit_pending_table.sv -----
// top level of the retransmit pending table
`timescale 1ns / 1ps
// table of up to SLOTS unacknowledged messages, each held as message id,
// last send time and packet handle in one slot memory; id zero marks an
// empty slot. a request is taken when start_i is high and busy_o is low;
// the block then reads one slot per cycle from slot 0 upward through the
// memory's single read port and stops at the first slot that decides the
// request. the one result appears in the cycle after the decision with
// done_o high for exactly one cycle and cannot be held off, so it must be
// captured then. busy_o is low again in that same cycle, so the next item
// may already be started while the result is shown. the user must write
// retransmit_seconds through cfg_we_i / cfg_wdata_i only while the block
// is idle; the block does not enforce this. it resets to 5.
module retransmit_pending_table
  import rpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command side
  input  logic                start_i,
  output logic                busy_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [ID_W-1:0]     msg_id_i,
  input  logic [TIME_W-1:0]   now_seconds_i,
  input  logic [HANDLE_W-1:0] packet_handle_i,
  // result side
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] packet_handle_out_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  logic [CFG_W-1:0] retx_seconds_q;
  mem_req_t         mem_req;
  slot_t            rd_slot;

  // retransmit interval in seconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retx_seconds_q <= RETX_RESET;
    end else if (cfg_we_i) begin
      retx_seconds_q <= cfg_wdata_i;
    end
  end

  // slot storage; writes land only at the end of an item and the next read
  // is issued no earlier than the following cycle, so no forwarding is needed
  rpt_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_slot_o (rd_slot)
  );

  // scan sequencer: read, decide, write back one slot
  rpt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .req_type_i      (req_type_i),
    .msg_id_i        (msg_id_i),
    .now_seconds_i   (now_seconds_i),
    .packet_handle_i (packet_handle_i),
    .retx_seconds_i  (retx_seconds_q),
    .rd_slot_i       (rd_slot),
    .mem_req_o       (mem_req),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .status_o        (status_o),
    .handle_o        (packet_handle_out_o)
  );

endmodule

// ----- rtl/rpt_slot_mem.sv -----
// slot memory with per-entry valid bits and a registered read
`timescale 1ns / 1ps
module rpt_slot_mem
  import rpt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output slot_t    rd_slot_o
);

  slot_t             mem_q [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  slot_t             rd_data_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
      rd_vld_q  <= valid_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // never-written entry reads as an empty slot
  always_comb begin
    rd_slot_o = rd_data_q;
    if (!rd_vld_q) begin
      rd_slot_o.id = '0;
    end
  end

endmodule

// ----- rtl/rpt_ctrl.sv -----
// request sequencer: scans slots one per cycle and writes back the deciding slot when the request succeeds
`timescale 1ns / 1ps
module rpt_ctrl
  import rpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [ID_W-1:0]     msg_id_i,
  input  logic [TIME_W-1:0]   now_seconds_i,
  input  logic [HANDLE_W-1:0] packet_handle_i,
  input  logic [CFG_W-1:0]    retx_seconds_i,
  input  slot_t               rd_slot_i,
  output mem_req_t            mem_req_o,
  output logic                busy_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [REQ_W-1:0]    req_q;
  logic [ID_W-1:0]     id_q;
  logic [TIME_W-1:0]   now_q;
  logic [HANDLE_W-1:0] handle_in_q;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;

  logic                accept;
  logic [TIME_W-1:0]   diff;
  logic                due;
  logic                hit;
  logic                miss_status_en;
  status_e             hit_status, miss_status;
  slot_t               wb_data;

  assign accept = start_i && (state_q == ST_IDLE);

  assign diff = (rd_slot_i.sent_time > now_q) ? (rd_slot_i.sent_time - now_q)
                                              : (now_q - rd_slot_i.sent_time);
  assign due  = (rd_slot_i.id != '0) && ({1'b0, diff} >= retx_seconds_i);

  // per-slot decision for the current request
  always_comb begin
    hit            = 1'b0;
    miss_status_en = 1'b1;
    hit_status     = STATUS_OK;
    miss_status    = STATUS_NONE;
    wb_data        = rd_slot_i;
    unique case (req_q)
      REQ_REGISTER: begin
        miss_status = STATUS_FULL;
        if (rd_slot_i.id == '0) begin
          hit     = 1'b1;
          wb_data = '{id: id_q, sent_time: now_q, packet: handle_in_q};
        end else if (rd_slot_i.id == id_q) begin
          hit        = 1'b1;
          hit_status = STATUS_DUP;
        end
      end
      REQ_DEREGISTER: begin
        miss_status = STATUS_NOT_FOUND;
        if (rd_slot_i.id == id_q) begin
          hit        = 1'b1;
          wb_data.id = '0;
        end
      end
      REQ_TAKE: begin
        if (due) begin
          hit               = 1'b1;
          wb_data.sent_time = now_q;
        end
      end
      default: begin
        miss_status_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    done_d    = 1'b0;
    status_d  = status_q;
    handle_d  = handle_q;
    mem_req_o = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: slot_q, wr_data: wb_data};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mem_req_o.rd_en = 1'b1;
          slot_d          = '0;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_req_o.wr_en = (hit_status == STATUS_OK);
          done_d          = 1'b1;
          status_d        = hit_status;
          handle_d        = (req_q == REQ_TAKE) ? rd_slot_i.packet : '0;
          state_d         = ST_IDLE;
        end else if (!miss_status_en || (slot_q == LAST_SLOT)) begin
          done_d   = 1'b1;
          status_d = miss_status;
          handle_d = '0;
          state_d  = ST_IDLE;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = slot_q + SlotW'(1);
          slot_d            = slot_q + SlotW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    handle_q <= handle_d;
    if (accept) begin
      req_q       <= req_type_i;
      id_q        <= msg_id_i;
      now_q       <= now_seconds_i;
      handle_in_q <= packet_handle_i;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign handle_o = handle_q;

endmodule
